@@ rtl/led_fire_heat_column_update_core_defines.svh @@
// Assertion helpers shared by the fire heat RTL.
// Both expect signals named clk and rst in the calling scope.
`ifndef LED_FIRE_HEAT_COLUMN_UPDATE_CORE_DEFINES_SVH
`define LED_FIRE_HEAT_COLUMN_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication.
`define LFH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfh: same-cycle check failed");

// Next-cycle implication.
`define LFH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfh: next-cycle check failed");

`endif

@@ rtl/lfh_pkg.sv @@
`default_nettype none

package lfh_pkg;

  localparam int unsigned COL_W      = 4;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned DRAW_W     = 7;
  localparam int unsigned ROLL_W     = 8;
  localparam int unsigned HEAT_W     = 8;
  localparam int unsigned SCALE_W    = 7;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // Cooling limit mapping constants
  localparam int unsigned SCALE_MIN   = 1;
  localparam int unsigned SCALE_MAX   = 100;
  localparam int unsigned SCALE_RST   = 50;
  localparam int unsigned LIMIT_TOP   = 93;
  localparam int unsigned LIMIT_SPAN  = 83;   // 93 - 10
  localparam int unsigned RECIP_99    = 10592; // ceil(2^20 / 99)
  localparam int unsigned RECIP_99_SH = 20;
  localparam int unsigned RECIP_3     = 683;   // ceil(2^11 / 3)
  localparam int unsigned RECIP_3_SH  = 11;
  localparam int unsigned THRESH_RST  = 80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_SCALE     = 1'b0,
    CFG_SPARK_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [DRAW_W-1:0] draw_max;
    logic [ROLL_W-1:0] threshold;
  } cfg_t;

  // Largest allowed cooling draw: limit - 1, limit = 93 - (s-1)*83/99
  function automatic logic [DRAW_W-1:0] draw_max_of(input logic [SCALE_W-1:0] scale);
    logic [SCALE_W-1:0] s;
    logic [13:0]        x;
    logic [27:0]        p;
    logic [DRAW_W-1:0]  q;
    s = scale;
    if (s < SCALE_W'(SCALE_MIN)) s = SCALE_W'(SCALE_MIN);
    if (s > SCALE_W'(SCALE_MAX)) s = SCALE_W'(SCALE_MAX);
    x = 14'(s - SCALE_W'(1)) * 14'(LIMIT_SPAN);
    p = 28'(x) * 28'(RECIP_99);
    q = DRAW_W'(p >> RECIP_99_SH);
    return DRAW_W'(LIMIT_TOP - 1) - q;
  endfunction

  localparam logic [DRAW_W-1:0] DRAW_MAX_RST = draw_max_of(SCALE_W'(SCALE_RST));

  function automatic logic [HEAT_W-1:0] sat_add8(input logic [HEAT_W-1:0] a,
                                                 input logic [HEAT_W-1:0] b);
    logic [HEAT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[HEAT_W] ? {HEAT_W{1'b1}} : s[HEAT_W-1:0];
  endfunction

  // x / 3 for x up to 765
  function automatic logic [HEAT_W-1:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(RECIP_3);
    return HEAT_W'(p >> RECIP_3_SH);
  endfunction

  // (h * 240) >> 8 == (h * 15) >> 4
  function automatic logic [HEAT_W-1:0] colour_of(input logic [HEAT_W-1:0] h);
    logic [11:0] p;
    p = {h, 4'b0000} - 12'(h);
    return p[11:4];
  endfunction

endpackage

`default_nettype wire

@@ rtl/lfh_cell_if.sv @@
`default_nettype none

interface lfh_cell_if;
  logic                        valid;
  logic                        ready;
  logic [lfh_pkg::COL_W-1:0]   column;
  logic [lfh_pkg::ROW_W-1:0]   row;
  logic [lfh_pkg::DRAW_W-1:0]  cool_amount;
  logic [lfh_pkg::ROLL_W-1:0]  spark_roll;
  logic                        spark_row;
  logic [lfh_pkg::HEAT_W-1:0]  spark_heat;

  modport source (output valid, column, row, cool_amount, spark_roll, spark_row,
                  spark_heat, input ready);
  modport sink   (input valid, column, row, cool_amount, spark_roll, spark_row,
                  spark_heat, output ready);
endinterface

`default_nettype wire

@@ rtl/lfh_pixel_if.sv @@
`default_nettype none

interface lfh_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [lfh_pkg::COL_W-1:0]   out_column;
  logic [lfh_pkg::ROW_W-1:0]   display_row;
  logic [lfh_pkg::HEAT_W-1:0]  heat_value;
  logic [lfh_pkg::HEAT_W-1:0]  colour_index;

  modport source (output valid, out_column, display_row, heat_value, colour_index,
                  input ready);
  modport sink   (input valid, out_column, display_row, heat_value, colour_index,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/lfh_cfg_if.sv @@
`default_nettype none

interface lfh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lfh_pkg::CFG_IDX_W-1:0]   index;
  logic [lfh_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/lfh_cfg_regs.sv @@
`default_nettype none

module lfh_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  lfh_cfg_if.sink        cfg,
  output lfh_pkg::cfg_t  cfg_val
);
  import lfh_pkg::*;

  logic [DRAW_W-1:0] draw_max;
  logic [ROLL_W-1:0] threshold;

  assign cfg.ready = 1'b1;

  // Keep the scale setting only as its mapped draw limit
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_max  <= DRAW_MAX_RST;
      threshold <= ROLL_W'(THRESH_RST);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_SPEED_SCALE:     draw_max  <= draw_max_of(cfg.data[SCALE_W-1:0]);
        CFG_SPARK_THRESHOLD: threshold <= cfg.data[ROLL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_val.draw_max  = draw_max;
  assign cfg_val.threshold = threshold;

endmodule

`default_nettype wire

@@ rtl/lfh_heat_mem.sv @@
`default_nettype none

module lfh_heat_mem #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [lfh_pkg::HEAT_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [lfh_pkg::HEAT_W-1:0] wr_data,
  output logic                       clear_busy
);
  import lfh_pkg::*;

  logic [HEAT_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_busy;

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Single write port, shared with the clearing sweep
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign clear_busy = clr_busy;

endmodule

`default_nettype wire

@@ rtl/lfh_cell_pipe.sv @@
`default_nettype none
`include "led_fire_heat_column_update_core_defines.svh"

module lfh_cell_pipe #(
  parameter int unsigned COLUMNS = 16,
  parameter int unsigned ROWS    = 16,
  localparam int unsigned ADDR_W = $clog2(COLUMNS * ROWS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lfh_pkg::cfg_t              cfg_val,
  input  logic                       clear_busy,
  lfh_cell_if.sink                   cells,
  lfh_pixel_if.source                pixel,
  output logic                       rd_en,
  output logic [ADDR_W-1:0]          rd_addr,
  input  logic [lfh_pkg::HEAT_W-1:0] rd_data,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [lfh_pkg::HEAT_W-1:0] wr_data
);
  import lfh_pkg::*;

  localparam int unsigned CALC_W = ADDR_W + COL_W;
  localparam logic [ROW_W-1:0] DROW_TOP = ROW_W'(ROWS - 1);

  // Read stage
  logic              in_range;
  logic              accept;
  logic [CALC_W-1:0] idx_full;
  logic [DRAW_W-1:0] draw_clamped;

  // Update stage
  logic              s1_valid;
  logic              s1_go;
  logic [ADDR_W-1:0] s1_addr;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [DRAW_W-1:0] s1_draw;
  logic              s1_fire;
  logic              s1_srow;
  logic [HEAT_W-1:0] s1_sheat;

  // Carried state
  logic [HEAT_W-1:0] cooled_prev;
  logic [HEAT_W-1:0] cooled_prev2;
  logic              spark_valid;
  logic [HEAT_W-1:0] spark_amt;
  logic              spark_valid_next;

  // Last write, for same-entry forwarding
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [HEAT_W-1:0] fwd_data;

  logic [HEAT_W-1:0] old_heat;
  logic [HEAT_W-1:0] cooled;
  logic [9:0]        sum3;
  logic [HEAT_W-1:0] avg;
  logic [HEAT_W-1:0] spark_add;
  logic [HEAT_W-1:0] result;

  // Output register
  logic              out_valid;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_drow;
  logic [HEAT_W-1:0] out_heat;

  // Accept while the clearing sweep is done and the update stage is free or moving on
  assign s1_go       = s1_valid && (!out_valid || pixel.ready);
  assign cells.ready = !clear_busy && (!s1_valid || s1_go);
  assign accept      = cells.valid && cells.ready;

  assign in_range = (32'(cells.column) < COLUMNS) && (32'(cells.row) < ROWS);
  assign idx_full = CALC_W'(cells.column) * CALC_W'(ROWS) + CALC_W'(cells.row);
  assign draw_clamped = (cells.cool_amount > cfg_val.draw_max) ? cfg_val.draw_max
                                                               : cells.cool_amount;

  // Drop out-of-range cells here: no read, no result
  assign rd_en   = accept && in_range;
  assign rd_addr = idx_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cells.ready) begin
      s1_valid <= cells.valid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr  <= idx_full[ADDR_W-1:0];
      s1_col   <= cells.column;
      s1_row   <= cells.row;
      s1_draw  <= draw_clamped;
      s1_fire  <= cells.spark_roll < cfg_val.threshold;
      s1_srow  <= cells.spark_row;
      s1_sheat <= cells.spark_heat;
    end
  end

  // Cool, blend and spark
  assign old_heat  = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
  assign cooled    = (old_heat > HEAT_W'(s1_draw)) ? old_heat - HEAT_W'(s1_draw) : '0;
  assign sum3      = 10'(cooled_prev) + {1'b0, cooled_prev2, 1'b0};
  assign avg       = div3(sum3);
  assign spark_add = sat_add8(cooled, (s1_row == '0) ? s1_sheat : spark_amt);

  always_comb begin
    result           = cooled;
    spark_valid_next = spark_valid;
    priority if (s1_row == '0) begin
      spark_valid_next = s1_fire && s1_srow;
      if (s1_fire && !s1_srow) result = spark_add;
    end else if (s1_row == ROW_W'(1)) begin
      spark_valid_next = 1'b0;
      if (spark_valid) result = spark_add;
    end else begin
      result = avg;
    end
  end

  assign wr_en   = s1_go;
  assign wr_addr = s1_addr;
  assign wr_data = result;

  // Advance carried state with each finished cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cooled_prev  <= '0;
      cooled_prev2 <= '0;
      spark_valid  <= 1'b0;
    end else if (s1_go) begin
      cooled_prev  <= cooled;
      cooled_prev2 <= cooled_prev;
      spark_valid  <= spark_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_row == '0)) begin
      spark_amt <= s1_sheat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_busy) begin
      fwd_valid <= 1'b0;
    end else if (s1_go) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fwd_addr <= s1_addr;
      fwd_data <= result;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_col  <= s1_col;
      out_drow <= DROW_TOP - s1_row;
      out_heat <= result;
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.out_column   = out_col;
  assign pixel.display_row  = out_drow;
  assign pixel.heat_value   = out_heat;
  assign pixel.colour_index = colour_of(out_heat);

  `LFH_ASSERT_IMP(a_no_accept_in_clear, clear_busy, !cells.ready)
  `LFH_ASSERT_NEXT(a_fwd_tracks_write, s1_go, fwd_valid && (fwd_addr == $past(s1_addr)))
  `LFH_ASSERT_NEXT(a_row1_takes_spark, s1_go && (s1_row == ROW_W'(1)), !spark_valid)
  `LFH_ASSERT_NEXT(a_update_fills_out, s1_go, out_valid)

endmodule

`default_nettype wire

@@ rtl/led_fire_heat_column_update_core.sv @@
// A result passes through the update stage register and then the output register
// before it appears on the pixel channel. Throughput: one cell per cycle while the
// pixel sink takes results, bound by the heat memory's single read and single write
// port; a same-entry read after write is forwarded. Reset: synchronous; the heat
// memory is then swept to zero, during which no cell request is accepted.
// Configuration writes are taken at any time and reset to scale 50, threshold 80.
`default_nettype none

module led_fire_heat_column_update_core #(
  parameter int unsigned COLUMNS = 16,
  parameter int unsigned ROWS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  lfh_cfg_if.sink     cfg,
  lfh_cell_if.sink    cells,
  lfh_pixel_if.source pixel
);
  import lfh_pkg::*;

  localparam int unsigned DEPTH  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  cfg_t              cfg_val;
  logic              clear_busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [HEAT_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HEAT_W-1:0] wr_data;

  lfh_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_val (cfg_val)
  );

  lfh_heat_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .clear_busy (clear_busy)
  );

  lfh_cell_pipe #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .cfg_val    (cfg_val),
    .clear_busy (clear_busy),
    .cells      (cells),
    .pixel      (pixel),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

endmodule

`default_nettype wire

@@ bench/led_fire_heat_column_update_core_tb.sv @@
`timescale 1ns / 1ps

module led_fire_heat_column_update_core_tb;
  import lfh_pkg::*;

  localparam int unsigned NUM_COLS     = 16;
  localparam int unsigned NUM_ROWS     = 16;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [DRAW_W-1:0] cool_amount;
    logic [ROLL_W-1:0] spark_roll;
    logic              spark_row;
    logic [HEAT_W-1:0] spark_heat;
  } cell_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  display_row;
    logic [HEAT_W-1:0] heat_value;
    logic [HEAT_W-1:0] colour_index;
  } pixel_t;

  logic clk;
  logic rst;

  lfh_cfg_if   cfg_bus ();
  lfh_cell_if  cell_bus ();
  lfh_pixel_if pix_bus ();

  led_fire_heat_column_update_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .cells (cell_bus),
    .pixel (pix_bus)
  );

  // Shadow of the block's state and registers
  logic [HEAT_W-1:0] heat_mem [NUM_COLS*NUM_ROWS];
  logic [HEAT_W-1:0] cooled_last;
  logic [HEAT_W-1:0] cooled_last2;
  logic              spark_armed;
  logic [HEAT_W-1:0] spark_amt;
  logic [SCALE_W-1:0]    scale_reg;
  logic [CFG_DATA_W-1:0] thresh_reg;

  cell_req_t cell_backlog [$];
  pixel_t    pending_pixels [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        cell_fire;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the heat of one cell; returns 0 when the cell is out of range
  function automatic bit fire_update(input cell_req_t c, output pixel_t p);
    int unsigned s, limit, draw, old, cooled, nxt, idx, sum;
    p = '0;
    if (c.column >= NUM_COLS || c.row >= NUM_ROWS) return 1'b0;
    s = scale_reg;
    if (s < 1) s = 1;
    if (s > 100) s = 100;
    limit = 93 - ((s - 1) * 83) / 99;
    draw = c.cool_amount;
    if (draw > limit - 1) draw = limit - 1;
    idx = c.column * NUM_ROWS + c.row;
    old = heat_mem[idx];
    cooled = (old > draw) ? old - draw : 0;
    if (c.row >= 2) begin
      nxt = (cooled_last + 2 * cooled_last2) / 3;
    end else if (c.row == 0) begin
      nxt = cooled;
      spark_armed = 1'b0;
      if (c.spark_roll < thresh_reg) begin
        if (c.spark_row == 1'b0) begin
          sum = cooled + c.spark_heat;
          nxt = (sum > 255) ? 255 : sum;
        end else begin
          spark_armed = 1'b1;
          spark_amt = c.spark_heat;
        end
      end
    end else begin
      nxt = cooled;
      if (spark_armed) begin
        sum = cooled + spark_amt;
        nxt = (sum > 255) ? 255 : sum;
        spark_armed = 1'b0;
      end
    end
    cooled_last2 = cooled_last;
    cooled_last = HEAT_W'(cooled);
    heat_mem[idx] = HEAT_W'(nxt);
    p.out_column = c.column;
    p.display_row = ROW_W'(NUM_ROWS - 1 - c.row);
    p.heat_value = HEAT_W'(nxt);
    p.colour_index = HEAT_W'((nxt * 240) >> 8);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_cell(input int unsigned col, input int unsigned row,
                          input int unsigned draw, input int unsigned roll,
                          input int unsigned srow, input int unsigned heat);
    cell_req_t c;
    c.column = COL_W'(col);
    c.row = ROW_W'(row);
    c.cool_amount = DRAW_W'(draw);
    c.spark_roll = ROLL_W'(roll);
    c.spark_row = srow[0];
    c.spark_heat = HEAT_W'(heat);
    cell_backlog.push_back(c);
  endtask

  // Random content for a given cell, mostly within the usual ranges
  task automatic add_random_cell(input int unsigned col, input int unsigned row);
    int unsigned draw, heat;
    draw = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(92);
    heat = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(254, 160);
    add_cell(col, row, draw, $urandom_range(255), $urandom_range(1), heat);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_SPEED_SCALE) scale_reg = SCALE_W'(val);
    else thresh_reg = val;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold until every request is taken and every pixel is back, then settle
  task automatic drain();
    do @(negedge clk);
    while (cell_backlog.size() != 0 || cell_bus.valid || pending_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Record accepted cell requests and predict their pixels
  always @(posedge clk) begin : take_cell
    pixel_t p;
    cell_fire = !rst && cell_bus.valid && cell_bus.ready;
    if (cell_fire) begin
      if (fire_update('{cell_bus.column, cell_bus.row, cell_bus.cool_amount,
                        cell_bus.spark_roll, cell_bus.spark_row, cell_bus.spark_heat}, p))
        pending_pixels.push_back(p);
    end
  end

  // Drive the next cell request from the backlog, idling at random
  always @(negedge clk) begin : drive_cell
    cell_req_t nxt;
    if (rst) begin
      cell_bus.valid <= 1'b0;
    end else if (!cell_bus.valid || cell_fire) begin
      if (cell_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = cell_backlog.pop_front();
        cell_bus.valid       <= 1'b1;
        cell_bus.column      <= nxt.column;
        cell_bus.row         <= nxt.row;
        cell_bus.cool_amount <= nxt.cool_amount;
        cell_bus.spark_roll  <= nxt.spark_roll;
        cell_bus.spark_row   <= nxt.spark_row;
        cell_bus.spark_heat  <= nxt.spark_heat;
      end else begin
        cell_bus.valid <= 1'b0;
      end
    end
  end

  // Stall the pixel side at random
  always @(negedge clk) begin
    pix_bus.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin : check_pixel
    pixel_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel col %0d row %0d with no prediction waiting",
               pix_bus.out_column, pix_bus.display_row);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_column", want.out_column, pix_bus.out_column);
        check_field("display_row", want.display_row, pix_bus.display_row);
        check_field("heat_value", want.heat_value, pix_bus.heat_value);
        check_field("colour_index", want.colour_index, pix_bus.colour_index);
      end
    end
  end

  initial begin : stimulus
    int unsigned scale_set [NUM_PHASES];
    int unsigned thresh_set [NUM_PHASES];
    int unsigned count, n, col;

    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_SPEED_SCALE;
    cfg_bus.data         = '0;
    cell_bus.valid       = 1'b0;
    cell_bus.column      = '0;
    cell_bus.row         = '0;
    cell_bus.cool_amount = '0;
    cell_bus.spark_roll  = '0;
    cell_bus.spark_row   = 1'b0;
    cell_bus.spark_heat  = '0;
    pix_bus.ready        = 1'b0;
    cell_fire            = 1'b0;
    mismatch_count       = 0;
    cycle_count          = 0;
    src_idle_pct         = 38;
    snk_idle_pct         = 69;

    // Reset state of the shadow
    foreach (heat_mem[i]) heat_mem[i] = '0;
    cooled_last  = '0;
    cooled_last2 = '0;
    spark_armed  = 1'b0;
    spark_amt    = '0;
    scale_reg    = SCALE_W'(SCALE_RST);
    thresh_reg   = CFG_DATA_W'(THRESH_RST);

    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: spark on row 0, averaging, spark on row 1, clamping, replacement
    add_cell(0, 0, 0, 0, 0, 254);
    add_cell(0, 1, 0, 255, 1, 200);
    add_cell(0, 2, 0, 0, 0, 200);
    add_cell(0, 3, 0, 0, 1, 200);
    add_cell(0, 4, 92, 0, 0, 200);
    add_cell(0, 0, 127, 79, 1, 255);
    add_cell(5, 1, 0, 0, 0, 160);
    add_cell(0, 1, 0, 0, 1, 160);
    add_cell(15, 15, 92, 0, 1, 0);
    add_cell(15, 0, 0, 80, 0, 254);
    add_cell(15, 0, 0, 0, 0, 0);
    add_cell(15, 0, 0, 0, 0, 159);
    add_cell(3, 0, 0, 0, 1, 200);
    add_cell(3, 0, 0, 255, 1, 200);
    add_cell(3, 1, 0, 0, 0, 200);
    add_cell(7, 9, 0, 0, 0, 200);
    add_cell(7, 3, 0, 0, 0, 200);
    add_cell(0, 0, 0, 0, 0, 254);
    add_cell(0, 0, 1, 0, 0, 254);
    add_cell(0, 0, 64, 0, 0, 255);
    add_cell(10, 0, 0, 0, 1, 255);
    add_cell(10, 1, 127, 0, 0, 160);
    add_cell(10, 2, 0, 255, 1, 255);
    drain();

    scale_set  = '{0, 1, 100, 127, 50, 77, 35, $urandom_range(127)};
    thresh_set = '{255, 0, 80, 128, 200, 1, 254, $urandom_range(255)};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        src_idle_pct = 38;
        snk_idle_pct = 69;
      end else if (ph < 6) begin
        src_idle_pct = 69;
        snk_idle_pct = 38;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_reg(CFG_SPEED_SCALE, CFG_DATA_W'(scale_set[ph]));
      write_reg(CFG_SPARK_THRESHOLD, CFG_DATA_W'(thresh_set[ph]));

      // Mostly whole columns bottom to top, some stray cells
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(4) != 0) begin
          col = $urandom_range(NUM_COLS - 1);
          for (int r = 0; r < NUM_ROWS; r++) add_random_cell(col, r);
          count += NUM_ROWS;
        end else begin
          n = $urandom_range(5, 1);
          for (int k = 0; k < n; k++)
            add_random_cell($urandom_range(NUM_COLS - 1), $urandom_range(NUM_ROWS - 1));
          count += n;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
